// File: rtl/sosd_pkg.sv
package sosd_pkg;

    localparam int MAX_VOXELS    = 262144;
    localparam int VOX_AW        = $clog2(MAX_VOXELS);
    localparam int POS_W         = VOX_AW + 1;
    localparam int MAX_SP        = 16384;
    localparam int SP_AW         = $clog2(MAX_SP);
    localparam int SPC_W         = SP_AW + 1;
    localparam int COORD_BITS    = 10;
    localparam int PT_W          = 3 * COORD_BITS;
    localparam int D2_W          = 22;
    localparam int ROOT_W        = 19;
    localparam int DIST_W        = 27;
    localparam int SUM_W         = 40;
    localparam int CNT_W         = 19;
    localparam int DEN_W         = CNT_W + 1;
    localparam int EXT_W         = 11;
    localparam int VAL_W         = 16;
    localparam int RATIO_W       = 17;
    localparam int CHAIN_CELLS   = 8;
    localparam int SHIFT_CNT_W   = $clog2(CHAIN_CELLS + 1);
    localparam int DRAIN_CYCLES  = CHAIN_CELLS + 3;
    localparam int DRAIN_W       = $clog2(DRAIN_CYCLES + 1);

    // configuration register indexes
    localparam logic [2:0] REG_LABEL  = 3'd0;
    localparam logic [2:0] REG_EXT_X  = 3'd1;
    localparam logic [2:0] REG_EXT_Y  = 3'd2;
    localparam logic [2:0] REG_EXT_Z  = 3'd3;
    localparam logic [2:0] REG_THREE_D = 3'd4;

    // one step of the distance chain: a held point, its running minimum and a passing point
    typedef struct packed {
        logic              av;
        logic [PT_W-1:0]   a;
        logic [D2_W-1:0]   md;
        logic              bv;
        logic [PT_W-1:0]   b;
    } link_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIR,
        ST_LOAD_RD,
        ST_LOAD_SH,
        ST_SQ_START,
        ST_SQ_WAIT,
        ST_NEXT,
        ST_STREAM,
        ST_DRAIN,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

endpackage

// File: rtl/sosd_ram.sv
module sosd_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/sosd_cell.sv
module sosd_cell
    import sosd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  shift,
    input  link_t prev,
    output link_t cur
);

    logic              av_reg, bv_reg, dv_reg;
    logic [PT_W-1:0]   a_reg, b_reg;
    logic [D2_W-1:0]   md_reg, d2_reg, d2_next;
    logic [COORD_BITS-1:0] pa, pb, dd;
    logic [2*COORD_BITS-1:0] sq;

    always_comb begin
        d2_next = '0;
        for (int k = 0; k < 3; k++) begin
            pa = a_reg[k*COORD_BITS +: COORD_BITS];
            pb = b_reg[k*COORD_BITS +: COORD_BITS];
            dd = (pa > pb) ? pa - pb : pb - pa;
            sq = dd * dd;
            d2_next = d2_next + D2_W'(sq);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            av_reg <= 1'b0;
            bv_reg <= 1'b0;
            dv_reg <= 1'b0;
        end else begin
            bv_reg <= prev.bv;
            dv_reg <= bv_reg;
            if (shift) begin
                av_reg <= prev.av;
            end
        end
    end

    always_ff @(posedge aclk) begin
        b_reg  <= prev.b;
        d2_reg <= d2_next;
        if (shift) begin
            a_reg  <= prev.a;
            md_reg <= prev.md;
        end else if (dv_reg && (d2_reg < md_reg)) begin
            md_reg <= d2_reg;
        end
    end

    assign cur = '{av: av_reg, a: a_reg, md: md_reg, bv: bv_reg, b: b_reg};

endmodule

// File: rtl/sosd_sqrt.sv
module sosd_sqrt
    import sosd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [D2_W-1:0]   radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int RAD_W = D2_W + 16;

    logic             busy_reg, done_reg;
    logic [RAD_W-1:0] v_reg, res_reg, bit_reg, trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg[0]) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // one result bit per cycle, restoring form
    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= {radicand, 16'b0};
            res_reg <= '0;
            bit_reg <= RAD_W'(1) << (RAD_W - 2);
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

// File: rtl/sosd_div.sv
module sosd_div
    import sosd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg, done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DEN_W-1:0]  rem_reg, div_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [DEN_W:0]    sh, diff;

    assign sh   = {rem_reg, quo_reg[SUM_W-1]};
    assign diff = sh - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            div_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            if (sh >= {1'b0, div_reg}) begin
                rem_reg <= diff[DEN_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= sh[DEN_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/segmentation_overlap_surface_distance.sv
// Voxel items: one per cycle while idle, no result until the final voxel.
// Final voxel: surface scan that reads each voxel and its six neighbours, then per direction
// batches of 8 surface points through the cell chain, each batch with the Nb points
// of the other surface streamed past it and a square root per point, then
// three divisions before the result item is registered.
// Reset is synchronous; masks and surface point stores are not cleared.
module segmentation_overlap_surface_distance
    import sosd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // segmented_value, reference_value
    input  logic         s_tlast,   // final_voxel
    output logic         m_tvalid,
    input  logic         m_tready,
    // segmented_count, reference_count, shared_count, segmented_surface_count,
    // reference_surface_count, union_count, false_positive_count,
    // false_negative_count, dice_ratio, tanimoto_ratio, hausdorff_distance,
    // mean_distance
    output logic [239:0] m_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_wdata
);

    localparam logic [2:0] STEP_C   = 3'd0;
    localparam logic [2:0] STEP_XP  = 3'd1;
    localparam logic [2:0] STEP_XM  = 3'd2;
    localparam logic [2:0] STEP_YP  = 3'd3;
    localparam logic [2:0] STEP_YM  = 3'd4;
    localparam logic [2:0] STEP_ZP  = 3'd5;
    localparam logic [2:0] STEP_ZM  = 3'd6;
    localparam logic [2:0] STEP_END = 3'd7;

    localparam logic [1:0] DIV_DICE = 2'd0;
    localparam logic [1:0] DIV_TANI = 2'd1;
    localparam logic [1:0] DIV_MEAN = 2'd2;

    localparam logic [EXT_W-1:0] EXT_LIM = EXT_W'(1 << COORD_BITS);

    function automatic logic [EXT_W-1:0] eff_ext(input logic [EXT_W-1:0] e);
        if (e == '0) begin
            return EXT_W'(1);
        end
        return (e > EXT_LIM) ? EXT_LIM : e;
    endfunction

    state_t state_reg, state_next;

    // configuration
    logic [VAL_W-1:0] label_reg;
    logic [EXT_W-1:0] extx_reg, exty_reg, extz_reg, ex, ey, ez;
    logic             three_d_reg;
    logic [2*EXT_W-1:0] plane_prod;
    logic [2*EXT_W-2:0] plane_reg;
    logic [3*EXT_W-2:0] vol_prod;
    logic [POS_W-1:0] vol_reg;
    logic [DIST_W-1:0] cap;

    // intake and scan
    logic             accept;
    logic [POS_W-1:0] pos_reg, sidx_reg;
    logic [COORD_BITS-1:0] sx_reg, sy_reg, sz_reg;
    logic [2:0]       step_reg;
    logic             ok_reg;
    logic             cen_s_reg, cen_r_reg, mxy_s_reg, mxy_r_reg, mz_s_reg, mz_r_reg;
    logic [CNT_W-1:0] cs_reg, cr_reg, sh_reg, un_reg, fp_reg, fn_reg, ss_reg, rs_reg;
    logic [POS_W+1:0] base_addr, nbr_addr;
    logic             nbr_ok;
    logic [1:0]       lab;
    logic             xyb, zb, surf_s, surf_r, scan_last;
    logic             mask_we, seg_we, ref_we;
    logic [1:0]       mask_wdata, mask_rdata;
    logic [PT_W-1:0]  pt_packed;

    // distance phase
    logic             dir_reg, in_valid_reg, loaded_any_reg, bin_v_reg, shift;
    logic [SPC_W-1:0] ns, nr, a_n, b_n, a_idx_reg, b_idx_reg;
    logic [SHIFT_CNT_W-1:0] shift_cnt_reg;
    logic [DRAIN_W-1:0] drain_reg;
    logic [D2_W-1:0]  ex_md_reg;
    logic [SP_AW-1:0] seg_raddr, ref_raddr;
    logic [PT_W-1:0]  seg_rdata, ref_rdata, a_rdata, b_rdata;
    logic [SUM_W-1:0] dsum_reg;
    logic [SUM_W:0]   dsum_add;
    logic [DIST_W-1:0] lmax_reg, best;
    link_t            chain [CHAIN_CELLS+1];
    logic             sq_start, sq_done;
    logic [ROOT_W-1:0] root;

    // division and result
    logic [1:0]       div_sel_reg;
    logic             div_start, div_done;
    logic [SUM_W-1:0] div_dvd, quotient;
    logic [DEN_W-1:0] div_den, denom;
    logic [RATIO_W-1:0] dice_reg, tani_reg;
    logic [DIST_W-1:0] mean_reg;
    logic             m_valid_reg;
    logic [239:0]     m_data_reg;

    assign ex = eff_ext(extx_reg);
    assign ey = eff_ext(exty_reg);
    assign ez = eff_ext(extz_reg);
    assign plane_prod = ex * ey;
    assign vol_prod   = plane_reg * ez;
    assign cap        = {vol_reg, 8'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            label_reg   <= VAL_W'(1);
            extx_reg    <= EXT_W'(64);
            exty_reg    <= EXT_W'(64);
            extz_reg    <= EXT_W'(64);
            three_d_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LABEL:   label_reg   <= cfg_wdata;
                REG_EXT_X:   extx_reg    <= cfg_wdata[EXT_W-1:0];
                REG_EXT_Y:   exty_reg    <= cfg_wdata[EXT_W-1:0];
                REG_EXT_Z:   extz_reg    <= cfg_wdata[EXT_W-1:0];
                REG_THREE_D: three_d_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        plane_reg <= plane_prod[2*EXT_W-2:0];
        vol_reg   <= (vol_prod > (3*EXT_W-1)'(MAX_VOXELS)) ? POS_W'(MAX_VOXELS)
                                                           : vol_prod[POS_W-1:0];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // ---------------- surface scan ----------------
    assign base_addr = {2'b0, sidx_reg};

    always_comb begin
        unique case (step_reg)
            STEP_XP: nbr_addr = base_addr + (POS_W+2)'(1);
            STEP_XM: nbr_addr = base_addr - (POS_W+2)'(1);
            STEP_YP: nbr_addr = base_addr + (POS_W+2)'(ex);
            STEP_YM: nbr_addr = base_addr - (POS_W+2)'(ex);
            STEP_ZP: nbr_addr = base_addr + (POS_W+2)'(plane_reg);
            STEP_ZM: nbr_addr = base_addr - (POS_W+2)'(plane_reg);
            default: nbr_addr = base_addr;
        endcase
    end

    assign nbr_ok = nbr_addr < {2'b0, vol_reg};
    assign lab    = mask_rdata & {2{ok_reg}};

    assign xyb = (sx_reg == '0) || (({1'b0, sx_reg} + EXT_W'(1)) >= ex)
              || (sy_reg == '0) || (({1'b0, sy_reg} + EXT_W'(1)) >= ey);
    assign zb  = (sz_reg == '0) || (({1'b0, sz_reg} + EXT_W'(1)) >= ez);

    // the last neighbour read lands in the final step
    assign surf_s = cen_s_reg && (xyb || mxy_s_reg
                  || (three_d_reg && (zb || mz_s_reg || !lab[0])));
    assign surf_r = cen_r_reg && (xyb || mxy_r_reg
                  || (three_d_reg && (zb || mz_r_reg || !lab[1])));

    assign scan_last = (sidx_reg + POS_W'(1)) >= vol_reg;
    assign pt_packed = {sz_reg, sy_reg, sx_reg};

    assign mask_we    = accept && (pos_reg < vol_reg);
    assign mask_wdata = {s_tdata[31:16] == label_reg, s_tdata[15:0] == label_reg};
    assign seg_we = (state_reg == ST_SCAN) && (step_reg == STEP_END) && surf_s
                 && (ss_reg < CNT_W'(MAX_SP));
    assign ref_we = (state_reg == ST_SCAN) && (step_reg == STEP_END) && surf_r
                 && (rs_reg < CNT_W'(MAX_SP));

    sosd_ram #(.WIDTH(2), .DEPTH(MAX_VOXELS)) u_mask (
        .aclk  (aclk),
        .we    (mask_we),
        .waddr (pos_reg[VOX_AW-1:0]),
        .wdata (mask_wdata),
        .raddr (nbr_addr[VOX_AW-1:0]),
        .rdata (mask_rdata)
    );

    // ---------------- distance chain ----------------
    assign ns  = (ss_reg < CNT_W'(MAX_SP)) ? ss_reg[SPC_W-1:0] : SPC_W'(MAX_SP);
    assign nr  = (rs_reg < CNT_W'(MAX_SP)) ? rs_reg[SPC_W-1:0] : SPC_W'(MAX_SP);
    assign a_n = dir_reg ? nr : ns;
    assign b_n = dir_reg ? ns : nr;

    assign seg_raddr = dir_reg ? b_idx_reg[SP_AW-1:0] : a_idx_reg[SP_AW-1:0];
    assign ref_raddr = dir_reg ? a_idx_reg[SP_AW-1:0] : b_idx_reg[SP_AW-1:0];
    assign a_rdata   = dir_reg ? ref_rdata : seg_rdata;
    assign b_rdata   = dir_reg ? seg_rdata : ref_rdata;

    sosd_ram #(.WIDTH(PT_W), .DEPTH(MAX_SP)) u_seg_pts (
        .aclk  (aclk),
        .we    (seg_we),
        .waddr (ss_reg[SP_AW-1:0]),
        .wdata (pt_packed),
        .raddr (seg_raddr),
        .rdata (seg_rdata)
    );

    sosd_ram #(.WIDTH(PT_W), .DEPTH(MAX_SP)) u_ref_pts (
        .aclk  (aclk),
        .we    (ref_we),
        .waddr (rs_reg[SP_AW-1:0]),
        .wdata (pt_packed),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    assign chain[0] = '{av: in_valid_reg, a: a_rdata, md: '1, bv: bin_v_reg, b: b_rdata};

    for (genvar i = 0; i < CHAIN_CELLS; i++) begin : g_cell
        sosd_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift   (shift),
            .prev    (chain[i]),
            .cur     (chain[i+1])
        );
    end

    sosd_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (ex_md_reg),
        .done     (sq_done),
        .root     (root)
    );

    assign best = (b_n == '0) ? cap
                : ((DIST_W'(root) < cap) ? DIST_W'(root) : cap);
    assign dsum_add = {1'b0, dsum_reg} + (SUM_W+1)'(best);

    // ---------------- division ----------------
    assign denom = {1'b0, cs_reg} + {1'b0, cr_reg};

    always_comb begin
        unique case (div_sel_reg)
            DIV_DICE: begin
                div_dvd = SUM_W'({sh_reg, 17'b0});
                div_den = denom;
            end
            DIV_TANI: begin
                div_dvd = SUM_W'({sh_reg, 16'b0});
                div_den = {1'b0, un_reg};
            end
            default: begin
                div_dvd = dsum_reg;
                div_den = denom;
            end
        endcase
    end

    sosd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (quotient)
    );

    // ---------------- control ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        shift      = 1'b0;
        sq_start   = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_tlast) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if ((step_reg == STEP_END) && scan_last) begin
                    state_next = ST_DIR;
                end
            end
            ST_DIR:     state_next = ST_LOAD_RD;
            ST_LOAD_RD: state_next = ST_LOAD_SH;
            ST_LOAD_SH: begin
                shift      = 1'b1;
                state_next = chain[CHAIN_CELLS].av ? ST_SQ_START : ST_NEXT;
            end
            ST_SQ_START: begin
                sq_start   = 1'b1;
                state_next = ST_SQ_WAIT;
            end
            ST_SQ_WAIT: begin
                if (sq_done) begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (shift_cnt_reg == SHIFT_CNT_W'(CHAIN_CELLS)) begin
                    if (loaded_any_reg) begin
                        state_next = ST_STREAM;
                    end else begin
                        state_next = dir_reg ? ST_DIV_START : ST_DIR;
                    end
                end else begin
                    state_next = ST_LOAD_RD;
                end
            end
            ST_STREAM: begin
                if (b_idx_reg >= b_n) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_reg == DRAIN_W'(DRAIN_CYCLES)) begin
                    state_next = ST_LOAD_RD;
                end
            end
            ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = (div_sel_reg == DIV_MEAN) ? ST_OUT : ST_DIV_START;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control counters and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            step_reg       <= STEP_C;
            dir_reg        <= 1'b0;
            in_valid_reg   <= 1'b0;
            loaded_any_reg <= 1'b0;
            bin_v_reg      <= 1'b0;
            shift_cnt_reg  <= '0;
            drain_reg      <= '0;
            div_sel_reg    <= DIV_DICE;
            m_valid_reg    <= 1'b0;
        end else begin
            bin_v_reg <= (state_reg == ST_STREAM) && (b_idx_reg < b_n);
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_tlast) begin
                            pos_reg  <= '0;
                            step_reg <= STEP_C;
                            dir_reg  <= 1'b0;
                        end else if (pos_reg < POS_W'(MAX_VOXELS)) begin
                            pos_reg <= pos_reg + POS_W'(1);
                        end
                    end
                end
                ST_SCAN: step_reg <= step_reg + 3'd1;
                ST_DIR: begin
                    shift_cnt_reg  <= '0;
                    loaded_any_reg <= 1'b0;
                end
                ST_LOAD_RD: in_valid_reg <= a_idx_reg < a_n;
                ST_LOAD_SH: begin
                    shift_cnt_reg  <= shift_cnt_reg + SHIFT_CNT_W'(1);
                    loaded_any_reg <= loaded_any_reg | in_valid_reg;
                end
                ST_NEXT: begin
                    if ((shift_cnt_reg == SHIFT_CNT_W'(CHAIN_CELLS)) && !loaded_any_reg) begin
                        dir_reg     <= 1'b1;
                        div_sel_reg <= DIV_DICE;
                    end
                    drain_reg <= '0;
                end
                ST_DRAIN: begin
                    drain_reg <= drain_reg + DRAIN_W'(1);
                    if (drain_reg == DRAIN_W'(DRAIN_CYCLES)) begin
                        shift_cnt_reg  <= '0;
                        loaded_any_reg <= 1'b0;
                    end
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        div_sel_reg <= div_sel_reg + 2'd1;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg) begin
                        m_valid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_tlast) begin
                    sidx_reg  <= '0;
                    sx_reg    <= '0;
                    sy_reg    <= '0;
                    sz_reg    <= '0;
                    cs_reg    <= '0;
                    cr_reg    <= '0;
                    sh_reg    <= '0;
                    un_reg    <= '0;
                    fp_reg    <= '0;
                    fn_reg    <= '0;
                    ss_reg    <= '0;
                    rs_reg    <= '0;
                    mxy_s_reg <= 1'b0;
                    mxy_r_reg <= 1'b0;
                    mz_s_reg  <= 1'b0;
                    mz_r_reg  <= 1'b0;
                    dsum_reg  <= '0;
                    lmax_reg  <= '0;
                end
            end
            ST_SCAN: begin
                ok_reg <= nbr_ok;
                case (step_reg) inside
                    STEP_XP: begin
                        cen_s_reg <= lab[0];
                        cen_r_reg <= lab[1];
                        cs_reg <= cs_reg + CNT_W'(lab[0]);
                        cr_reg <= cr_reg + CNT_W'(lab[1]);
                        sh_reg <= sh_reg + CNT_W'(lab[0] & lab[1]);
                        un_reg <= un_reg + CNT_W'(lab[0] | lab[1]);
                        fp_reg <= fp_reg + CNT_W'(lab[0] & ~lab[1]);
                        fn_reg <= fn_reg + CNT_W'(lab[1] & ~lab[0]);
                    end
                    STEP_XM, STEP_YP, STEP_YM, STEP_ZP: begin
                        mxy_s_reg <= mxy_s_reg | ~lab[0];
                        mxy_r_reg <= mxy_r_reg | ~lab[1];
                    end
                    STEP_ZM: begin
                        mz_s_reg <= ~lab[0];
                        mz_r_reg <= ~lab[1];
                    end
                    STEP_END: begin
                        mxy_s_reg <= 1'b0;
                        mxy_r_reg <= 1'b0;
                        mz_s_reg  <= 1'b0;
                        mz_r_reg  <= 1'b0;
                        ss_reg    <= ss_reg + CNT_W'(surf_s);
                        rs_reg    <= rs_reg + CNT_W'(surf_r);
                        sidx_reg  <= sidx_reg + POS_W'(1);
                        if (({1'b0, sx_reg} + EXT_W'(1)) >= ex) begin
                            sx_reg <= '0;
                            if (({1'b0, sy_reg} + EXT_W'(1)) >= ey) begin
                                sy_reg <= '0;
                                sz_reg <= sz_reg + COORD_BITS'(1);
                            end else begin
                                sy_reg <= sy_reg + COORD_BITS'(1);
                            end
                        end else begin
                            sx_reg <= sx_reg + COORD_BITS'(1);
                        end
                    end
                    default: ;
                endcase
            end
            ST_DIR: a_idx_reg <= '0;
            ST_LOAD_RD: begin
                if (a_idx_reg < a_n) begin
                    a_idx_reg <= a_idx_reg + SPC_W'(1);
                end
            end
            ST_LOAD_SH: ex_md_reg <= chain[CHAIN_CELLS].md;
            ST_SQ_WAIT: begin
                if (sq_done) begin
                    dsum_reg <= dsum_add[SUM_W] ? '1 : dsum_add[SUM_W-1:0];
                    if (best > lmax_reg) begin
                        lmax_reg <= best;
                    end
                end
            end
            ST_NEXT: b_idx_reg <= '0;
            ST_STREAM: begin
                if (b_idx_reg < b_n) begin
                    b_idx_reg <= b_idx_reg + SPC_W'(1);
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    unique case (div_sel_reg)
                        DIV_DICE: dice_reg <= (div_den == '0) ? '0 : quotient[RATIO_W-1:0];
                        DIV_TANI: tani_reg <= (div_den == '0) ? '0 : quotient[RATIO_W-1:0];
                        default: begin
                            if (div_den == '0) begin
                                mean_reg <= '0;
                            end else if (quotient > SUM_W'({DIST_W{1'b1}})) begin
                                mean_reg <= '1;
                            end else begin
                                mean_reg <= quotient[DIST_W-1:0];
                            end
                        end
                    endcase
                end
            end
            ST_OUT: begin
                if (!m_valid_reg) begin
                    m_data_reg <= {mean_reg, lmax_reg, tani_reg, dice_reg, fn_reg, fp_reg,
                                   un_reg, rs_reg, ss_reg, sh_reg, cr_reg, cs_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_out_from_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result item raised outside the output state");

    a_surf_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> ((ss_reg <= sidx_reg) && (rs_reg <= sidx_reg)))
        else $error("surface count exceeds scanned voxels");

    a_stream_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STREAM) |-> loaded_any_reg)
        else $error("streaming with an empty cell chain");

endmodule

// File: tb/segmentation_overlap_surface_distance_test.sv
module segmentation_overlap_surface_distance_test;
    import sosd_pkg::*;

    class overlap_scoreboard;
        bit              seg_mask[MAX_VOXELS];
        bit              ref_mask[MAX_VOXELS];
        int unsigned     written_max;
        int unsigned     label;
        int unsigned     ext_reg[3];
        bit              three_d;
        int unsigned     gx, gy, gz, gvol, pos;
        bit [239:0]      expected_q[$];
        int              mismatches, results_seen;

        function new();
            label = 1;
            ext_reg = '{64, 64, 64};
            three_d = 1;
            pos = 0;
            written_max = 0;
            mismatches = 0;
            results_seen = 0;
            geometry();
        endfunction

        function int unsigned clamp_extent(int unsigned e);
            if (e == 0) return 1;
            return (e > (1 << COORD_BITS)) ? (1 << COORD_BITS) : e;
        endfunction

        function void geometry();
            longint unsigned v;
            gx = clamp_extent(ext_reg[0]);
            gy = clamp_extent(ext_reg[1]);
            gz = clamp_extent(ext_reg[2]);
            v = longint'(gx) * gy * gz;
            gvol = (v > MAX_VOXELS) ? MAX_VOXELS : int'(v);
        endfunction

        function void write_reg(logic [2:0] idx, int unsigned val);
            case (idx)
                REG_LABEL:   label = val & 16'hFFFF;
                REG_EXT_X:   ext_reg[0] = val & 11'h7FF;
                REG_EXT_Y:   ext_reg[1] = val & 11'h7FF;
                REG_EXT_Z:   ext_reg[2] = val & 11'h7FF;
                REG_THREE_D: three_d = val[0];
                default: ;
            endcase
            geometry();
        endfunction

        function bit is_set(bit which, int unsigned x, int unsigned y, int unsigned z);
            longint unsigned idx;
            idx = x + longint'(gx) * (y + longint'(gy) * z);
            if (idx >= gvol) return 0;
            return which ? ref_mask[idx] : seg_mask[idx];
        endfunction

        // collect surface voxels of one mask, packed x | y << C | z << 2C
        function int unsigned surface(bit which, ref int unsigned pts[$]);
            int unsigned cnt, x, y, z;
            bit on;
            cnt = 0; x = 0; y = 0; z = 0;
            pts.delete();
            for (int unsigned i = 0; i < gvol; i++) begin
                if (which ? ref_mask[i] : seg_mask[i]) begin
                    on = (x == 0) || (x + 1 >= gx) || (y == 0) || (y + 1 >= gy);
                    if (!on)
                        on = !is_set(which, x + 1, y, z) || !is_set(which, x - 1, y, z)
                            || !is_set(which, x, y + 1, z) || !is_set(which, x, y - 1, z);
                    if (three_d && !on)
                        on = (z == 0) || (z + 1 >= gz)
                            || !is_set(which, x, y, z + 1) || !is_set(which, x, y, z - 1);
                    if (on) begin
                        if (cnt < MAX_SP)
                            pts.push_back(x | (y << COORD_BITS) | (z << (2 * COORD_BITS)));
                        cnt++;
                    end
                end
                x++;
                if (x >= gx) begin
                    x = 0;
                    y++;
                    if (y >= gy) begin
                        y = 0;
                        z++;
                    end
                end
            end
            return cnt;
        endfunction

        function longint unsigned floor_root(longint unsigned v);
            longint unsigned r, t;
            r = 0;
            for (int i = 24; i >= 0; i--) begin
                t = r | (64'd1 << i);
                if (t * t <= v) r = t;
            end
            return r;
        endfunction

        function void nearest(ref int unsigned a[$], ref int unsigned b[$],
                              ref longint unsigned total, ref longint unsigned worst);
            longint unsigned best, md, d2, p, q, d;
            for (int i = 0; i < a.size(); i++) begin
                best = longint'(gvol) * 256;
                if (b.size() > 0) begin
                    md = '1;
                    foreach (b[j]) begin
                        d2 = 0;
                        for (int k = 0; k < 3; k++) begin
                            p = (a[i] >> (k * COORD_BITS)) & 10'h3FF;
                            q = (b[j] >> (k * COORD_BITS)) & 10'h3FF;
                            d = (p > q) ? p - q : q - p;
                            d2 += d * d;
                        end
                        if (d2 < md) md = d2;
                    end
                    md = floor_root(md << 16);
                    if (md < best) best = md;
                end
                total += best;
                if (total > 64'hFF_FFFF_FFFF) total = 64'hFF_FFFF_FFFF;
                if (best > worst) worst = best;
            end
        endfunction

        function void note_voxel(logic [15:0] seg, logic [15:0] rv, logic last);
            longint unsigned cs, cr, sh, un, fp, fn, ss, rs, den, total, worst, mean;
            int unsigned spts[$], rpts[$];
            bit [RATIO_W-1:0] dice, tani;
            if (pos < gvol) begin
                seg_mask[pos] = (seg == label);
                ref_mask[pos] = (rv == label);
                if (pos + 1 > written_max) written_max = pos + 1;
            end
            if (pos < MAX_VOXELS) pos++;
            if (!last) return;
            pos = 0;
            cs = 0; cr = 0; sh = 0; un = 0; fp = 0; fn = 0;
            for (int unsigned i = 0; i < gvol; i++) begin
                cs += seg_mask[i];
                cr += ref_mask[i];
                sh += seg_mask[i] & ref_mask[i];
                un += seg_mask[i] | ref_mask[i];
                fp += seg_mask[i] & !ref_mask[i];
                fn += ref_mask[i] & !seg_mask[i];
            end
            ss = surface(0, spts);
            rs = surface(1, rpts);
            total = 0;
            worst = 0;
            nearest(spts, rpts, total, worst);
            nearest(rpts, spts, total, worst);
            den = cs + cr;
            dice = den ? (2 * sh * 65536) / den : 0;
            tani = un ? (sh * 65536) / un : 0;
            mean = den ? total / den : 0;
            if (mean > 27'h7FF_FFFF) mean = 27'h7FF_FFFF;
            expected_q.push_back({mean[26:0], worst[26:0], tani, dice, fn[18:0], fp[18:0],
                                  un[18:0], rs[18:0], ss[18:0], sh[18:0], cr[18:0], cs[18:0]});
        endfunction

        function void check_result(logic [239:0] got);
            int widths[12] = '{19, 19, 19, 19, 19, 19, 19, 19, 17, 17, 27, 27};
            string names[12] = '{"segmented_count", "reference_count", "shared_count",
                "segmented_surface_count", "reference_surface_count", "union_count",
                "false_positive_count", "false_negative_count", "dice_ratio",
                "tanimoto_ratio", "hausdorff_distance", "mean_distance"};
            bit [239:0] want;
            int lo;
            longint unsigned e, a;
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h", got);
                return;
            end
            want = expected_q.pop_front();
            lo = 0;
            for (int f = 0; f < 12; f++) begin
                e = (want >> lo) & ((64'd1 << widths[f]) - 1);
                a = (got >> lo) & ((64'd1 << widths[f]) - 1);
                if (e !== a) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d %s: expected %0d, got %0d",
                                 results_seen, names[f], e, a);
                end
                lo += widths[f];
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         s_tlast = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [239:0] m_tdata;
    logic         cfg_wr_en = 0;
    logic [2:0]   cfg_index = '0;
    logic [15:0]  cfg_wdata = '0;

    overlap_scoreboard sb = new();
    bit vld_hi;
    int burst_left, items_sent, quiet_left;

    segmentation_overlap_surface_distance DUT (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver: modes change every stretch of cycles
    int rx_mode, rx_left, rx_phase;
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            default: m_tready <= (rx_phase % 5) > 1;
        endcase
    end

    // sample at the falling edge; the item moves at the next rising edge
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    task automatic send_voxel(logic [15:0] seg, logic [15:0] rv, logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {rv, seg};
        s_tlast <= last;
        vld_hi = 1;
        forever begin
            @(negedge aclk);
            if (s_tready) break;
            @(posedge aclk);
        end
        sb.note_voxel(seg, rv, last);
        items_sent++;
        @(posedge aclk);
        gap = 0;
        if (quiet_left > 0) quiet_left--;
        else if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 9) == 0) quiet_left = $urandom_range(30, 120);
        end else burst_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            vld_hi = 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // hold off until every expected item has arrived and the block is idle
    task automatic settle();
        if (vld_hi) begin
            s_tvalid <= 1'b0;
            vld_hi = 0;
        end
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic configure(logic [15:0] lab, logic [15:0] ex, logic [15:0] ey,
                             logic [15:0] ez, logic [15:0] td);
        settle();
        write_reg(REG_LABEL, lab);
        write_reg(REG_EXT_X, ex);
        write_reg(REG_EXT_Y, ey);
        write_reg(REG_EXT_Z, ez);
        write_reg(REG_THREE_D, td);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] voxel_value(bit marked);
        logic [15:0] v;
        if (marked) return sb.label;
        v = $urandom_range(0, 65535);
        if (v == sb.label) v = ~v;
        return v;
    endfunction

    task automatic random_volume(int n, int density);
        bit s, r;
        for (int i = 0; i < n; i++) begin
            s = $urandom_range(0, 99) < density;
            r = ($urandom_range(0, 9) < 8) ? s : !s;
            send_voxel(voxel_value(s), voxel_value(r), i == n - 1);
        end
    endtask

    initial begin
        int v, n, pick;
        logic [15:0] lab;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // 2x2x2 cube with all-ones label, mixed overlap
        configure(16'hFFFF, 2, 2, 2, 1);
        send_voxel(16'hFFFF, 16'hFFFF, 0);
        send_voxel(16'h0000, 16'hFFFF, 0);
        send_voxel(16'hFFFF, 16'h0000, 0);
        send_voxel(16'h0000, 16'h0000, 0);
        send_voxel(16'hFFFF, 16'hFFFF, 0);
        send_voxel(16'hFFFE, 16'hFFFF, 0);
        send_voxel(16'hFFFF, 16'h7FFF, 0);
        send_voxel(16'hFFFF, 16'hFFFF, 1);
        // zero extents count as one; extra voxels beyond capacity are dropped
        configure(16'h0000, 0, 3, 0, 0);
        send_voxel(16'h0000, 16'h0000, 0);
        send_voxel(16'h0000, 16'h5555, 0);
        send_voxel(16'hAAAA, 16'h0000, 0);
        send_voxel(16'h0000, 16'h0000, 0);
        send_voxel(16'h1234, 16'h0000, 1);
        // nothing labelled: empty surfaces and zero denominators
        configure(16'h0005, 2, 2, 1, 0);
        repeat (3) send_voxel(16'h0004, 16'h0006, 0);
        send_voxel(16'h8000, 16'h0001, 1);
        // short volume reusing older mask entries
        configure(16'hFFFF, 2, 2, 2, 1);
        send_voxel(16'h0000, 16'hFFFF, 0);
        send_voxel(16'hFFFF, 16'h0000, 0);
        send_voxel(16'hFFFF, 16'hFFFF, 1);
        // widest extent, saturated to the coordinate range; sparse content
        configure(16'h0007, 2047, 0, 0, 0);
        random_volume(1025, 3);

        items_sent = 0;
        while (items_sent < 550 || sb.results_seen < 40) begin
            pick = $urandom_range(0, 9);
            lab = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : $urandom_range(0, 65535);
            configure(lab, $urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 3),
                      $urandom_range(0, 1));
            v = sb.gvol;
            pick = $urandom_range(0, 9);
            if (pick == 0 && v > 1 && sb.written_max >= v) n = $urandom_range(1, v - 1);
            else if (pick == 1) n = v + $urandom_range(1, 3);
            else n = v;
            random_volume(n, $urandom_range(0, 100));
        end

        settle();
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
